// ===== rtl/core/multilevel_priority_run_queue_top_assert.svh =====
// Assertion macros for the run queue scheduler.
`ifndef MULTILEVEL_PRIORITY_RUN_QUEUE_TOP_ASSERT_SVH
`define MULTILEVEL_PRIORITY_RUN_QUEUE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// checked only outside reset
`define MPRQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define MPRQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPRQ_ASSERT(lbl, prop, msg)
`define MPRQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/mprq_pkg.sv =====
package mprq_pkg;

	typedef logic [5:0] id_t;
	typedef logic [7:0] prio_t;

	// request kinds
	localparam logic [1:0] REQ_ENQUEUE  = 2'd0;
	localparam logic [1:0] REQ_DEQUEUE  = 2'd1;
	localparam logic [1:0] REQ_YIELD    = 2'd2;
	localparam logic [1:0] REQ_RESERVED = 2'd3;

	// result status
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_QUEUED    = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// register select bit of paddr
	localparam logic CFG_IDLE_ID = 1'b0;
	localparam logic CFG_LEVELS  = 1'b1;

	typedef struct packed {
		logic [1:0] req_type;
		id_t        thread_id;
		prio_t      thread_base_priority;
		prio_t      thread_boost;
		id_t        current_id;
		prio_t      current_base_priority;
		prio_t      current_boost;
		logic       voluntary;
	} req_t;

	typedef struct packed {
		id_t        next_thread_id;
		logic       switched;
		logic       switch_pending;
		logic [1:0] status;
	} rsp_t;

	// one write into a link memory
	typedef struct packed {
		logic we;
		id_t  addr;
		id_t  data;
	} link_wr_t;

endpackage

// ===== rtl/core/multilevel_priority_run_queue_top.sv =====
// Multilevel priority run queue: one FIFO of threads per priority level.
// Requests come in on req_valid/req_ready/req_data, results leave on
// rsp_valid/rsp_ready/rsp_data, one result per request. Registers sit on
// an APB port: idle thread id at 0x0, levels in use at 0x4.
// One request is worked at a time by a sequencer around the link memories
// (one read and one write per memory per cycle). A dequeue walks the
// previous links from the thread toward its level head, one memory read
// per step.
// The next request is taken once the sequencer is back to idle, even while
// the previous result still waits in the output register. If rsp_ready
// stays low, the finished request holds in its last step until the output
// register frees.
// Reset clears all queued marks, level occupancy, the pending flag and the
// registers (idle thread 0, 16 levels); link memories need no clearing.
`include "multilevel_priority_run_queue_top_assert.svh"
module multilevel_priority_run_queue_top #(
	parameter int MAX_THREADS = 64,
	parameter int MAX_LEVELS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  mprq_pkg::req_t      req_data,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output mprq_pkg::rsp_t      rsp_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	localparam int TW  = $clog2(MAX_THREADS);
	localparam int LVW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EXEC  = 4'd1;
	localparam logic [3:0] S_WALK  = 4'd2;
	localparam logic [3:0] S_WCHK  = 4'd3;
	localparam logic [3:0] S_UNRD  = 4'd4;
	localparam logic [3:0] S_UNWR  = 4'd5;
	localparam logic [3:0] S_YREQ  = 4'd6;
	localparam logic [3:0] S_PUSH  = 4'd7;
	localparam logic [3:0] S_PUSH2 = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0]            state_q;
	logic [MAX_THREADS-1:0] queued_q;
	logic [MAX_LEVELS-1:0] nonempty_q;
	logic                  pending_q;
	mprq_pkg::id_t         idle_id_q;
	logic [4:0]            levels_q;
	logic                  rsp_valid_q;

	mprq_pkg::req_t        req_q;
	mprq_pkg::id_t         thr_q;
	mprq_pkg::id_t         node_q;
	logic [LVW-1:0]        lvl_q;
	logic [TW-1:0]         cnt_q;
	mprq_pkg::id_t         next_q;
	logic                  switched_q;
	logic [1:0]            status_q;
	mprq_pkg::rsp_t        rsp_q;
	mprq_pkg::id_t         head_q [MAX_LEVELS];
	mprq_pkg::id_t         tail_q [MAX_LEVELS];

	mprq_pkg::link_wr_t    nx_wr;
	mprq_pkg::link_wr_t    pv_wr;
	mprq_pkg::id_t         rd_addr;
	mprq_pkg::id_t         nx_rdata;
	mprq_pkg::id_t         pv_rdata;

	function automatic logic in_range(input mprq_pkg::id_t t);
		return 32'(t) < MAX_THREADS;
	endfunction

	function automatic mprq_pkg::id_t tix(input mprq_pkg::id_t t);
		return in_range(t) ? t : '0;
	endfunction

	function automatic mprq_pkg::prio_t eff_prio(input mprq_pkg::prio_t b,
		input mprq_pkg::prio_t k);
		logic [8:0] s;
		s = {1'b0, b} + {1'b0, k};
		return s[8] ? 8'hff : s[7:0];
	endfunction

	function automatic logic [LVW-1:0] level_of(input mprq_pkg::prio_t p,
		input logic [4:0] n_cfg);
		logic [7:0] n;
		logic [7:0] lim;
		n = (n_cfg == 5'd0) ? 8'd1 : {3'b0, n_cfg};
		if (n > 8'(MAX_LEVELS)) begin
			n = 8'(MAX_LEVELS);
		end
		lim = n - 8'd1;
		return LVW'((p > lim) ? lim : p);
	endfunction

	// highest occupied level
	function automatic logic [LVW-1:0] top_of(input logic [MAX_LEVELS-1:0] ne);
		logic [LVW-1:0] r;
		r = '0;
		for (int i = 0; i < MAX_LEVELS; i++) begin
			if (ne[i]) begin
				r = LVW'(i);
			end
		end
		return r;
	endfunction

	// request decode
	logic                  t_in;
	logic                  c_in;
	logic [TW-1:0]         t_idx;
	logic [TW-1:0]         c_idx;
	logic [TW-1:0]         thr_idx;
	mprq_pkg::prio_t       e_t;
	mprq_pkg::prio_t       e_c;
	mprq_pkg::prio_t       e_cy;
	logic [LVW-1:0]        lvl_t;
	logic [LVW-1:0]        lvl_c;
	logic [LVW-1:0]        top_lvl;
	logic                  top_hit;
	mprq_pkg::id_t         p_id;
	mprq_pkg::id_t         n_id;
	logic                  is_head;
	logic                  is_tail;
	logic                  rsp_load;
	logic                  accept;

	assign t_in    = in_range(req_q.thread_id);
	assign c_in    = in_range(req_q.current_id);
	assign t_idx   = TW'(req_q.thread_id);
	assign c_idx   = TW'(req_q.current_id);
	assign thr_idx = TW'(thr_q);
	assign e_t     = eff_prio(req_q.thread_base_priority, req_q.thread_boost);
	assign e_c     = eff_prio(req_q.current_base_priority, req_q.current_boost);
	assign e_cy    = eff_prio(req_q.current_base_priority,
		req_q.voluntary ? 8'd0 : req_q.current_boost);
	assign lvl_t   = level_of(e_t, levels_q);
	assign lvl_c   = level_of(e_cy, levels_q);
	assign top_lvl = top_of(nonempty_q);
	assign top_hit = |nonempty_q;
	assign p_id    = tix(pv_rdata);
	assign n_id    = tix(nx_rdata);
	assign is_head = head_q[lvl_q] == thr_q;
	assign is_tail = tail_q[lvl_q] == thr_q;

	assign req_ready = state_q == S_IDLE;
	assign accept    = req_valid && req_ready;
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// config port
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			mprq_pkg::CFG_IDLE_ID: prdata = {26'd0, idle_id_q};
			mprq_pkg::CFG_LEVELS:  prdata = {27'd0, levels_q};
			default:               prdata = '0;
		endcase
	end

	// link memory writes
	always_comb begin
		nx_wr = '0;
		pv_wr = '0;
		rd_addr = (state_q == S_WALK) ? node_q : thr_q;
		unique case (state_q)
			S_UNWR: begin
				priority if (is_head && is_tail) begin
				end else if (is_head) begin
					pv_wr = '{we: 1'b1, addr: n_id, data: n_id};
				end else if (is_tail) begin
					nx_wr = '{we: 1'b1, addr: p_id, data: p_id};
				end else begin
					nx_wr = '{we: 1'b1, addr: p_id, data: n_id};
					pv_wr = '{we: 1'b1, addr: n_id, data: p_id};
				end
			end
			S_PUSH: begin
				if (nonempty_q[lvl_q]) begin
					nx_wr = '{we: 1'b1, addr: tail_q[lvl_q], data: thr_q};
					pv_wr = '{we: 1'b1, addr: thr_q, data: tail_q[lvl_q]};
				end else begin
					nx_wr = '{we: 1'b1, addr: thr_q, data: thr_q};
					pv_wr = '{we: 1'b1, addr: thr_q, data: thr_q};
				end
			end
			S_PUSH2: nx_wr = '{we: 1'b1, addr: thr_q, data: thr_q};
			default: begin
			end
		endcase
	end

	mprq_link_ram #(
		.DEPTH(MAX_THREADS)
	) u_links (
		.clk      (clk),
		.nx_wr    (nx_wr),
		.pv_wr    (pv_wr),
		.rd_addr  (rd_addr),
		.nx_rdata (nx_rdata),
		.pv_rdata (pv_rdata)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			queued_q    <= '0;
			nonempty_q  <= '0;
			pending_q   <= 1'b0;
			idle_id_q   <= '0;
			levels_q    <= 5'd16;
			rsp_valid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite) begin
				unique case (paddr[2])
					mprq_pkg::CFG_IDLE_ID: idle_id_q <= pwdata[5:0];
					mprq_pkg::CFG_LEVELS:  levels_q  <= pwdata[4:0];
					default: begin
					end
				endcase
			end
			// output register: load a finished request, else drop on accept
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_EXEC;
				S_EXEC: begin
					unique case (req_q.req_type)
						mprq_pkg::REQ_ENQUEUE: begin
							if (!t_in || queued_q[t_idx]) begin
								state_q <= S_DONE;
							end else begin
								if (e_t > e_c) pending_q <= 1'b1;
								state_q <= S_PUSH;
							end
						end
						mprq_pkg::REQ_DEQUEUE: begin
							if (!t_in || !queued_q[t_idx] || !nonempty_q[lvl_t]) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_WALK;
							end
						end
						mprq_pkg::REQ_YIELD: begin
							pending_q <= 1'b0;
							state_q   <= top_hit ? S_UNRD : S_YREQ;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_WALK: begin
					priority if (head_q[lvl_q] == node_q) state_q <= S_UNRD;
					else if (cnt_q == TW'(MAX_THREADS - 1)) state_q <= S_DONE;
					else state_q <= S_WCHK;
				end
				S_WCHK: state_q <= (p_id == node_q) ? S_DONE : S_WALK;
				S_UNRD: state_q <= S_UNWR;
				S_UNWR: begin
					queued_q[thr_idx] <= 1'b0;
					if (is_head && is_tail) nonempty_q[lvl_q] <= 1'b0;
					state_q <= (req_q.req_type == mprq_pkg::REQ_YIELD) ? S_YREQ : S_DONE;
				end
				S_YREQ: begin
					if (next_q != req_q.current_id && c_in && !queued_q[c_idx]) begin
						state_q <= S_PUSH;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_PUSH: begin
					if (nonempty_q[lvl_q]) begin
						state_q <= S_PUSH2;
					end else begin
						nonempty_q[lvl_q] <= 1'b1;
						queued_q[thr_idx] <= 1'b1;
						state_q           <= S_DONE;
					end
				end
				S_PUSH2: begin
					queued_q[thr_idx] <= 1'b1;
					state_q           <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request payload, list ends and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_q      <= req_data;
					status_q   <= mprq_pkg::ST_OK;
					switched_q <= 1'b0;
					next_q     <= req_data.current_id;
				end
			end
			S_EXEC: begin
				unique case (req_q.req_type)
					mprq_pkg::REQ_ENQUEUE: begin
						if (!t_in) status_q <= mprq_pkg::ST_NOT_FOUND;
						else if (queued_q[t_idx]) status_q <= mprq_pkg::ST_QUEUED;
						thr_q <= req_q.thread_id;
						lvl_q <= lvl_t;
					end
					mprq_pkg::REQ_DEQUEUE: begin
						if (!t_in || !queued_q[t_idx] || !nonempty_q[lvl_t]) begin
							status_q <= mprq_pkg::ST_NOT_FOUND;
						end
						thr_q  <= req_q.thread_id;
						node_q <= req_q.thread_id;
						cnt_q  <= '0;
						lvl_q  <= lvl_t;
					end
					mprq_pkg::REQ_YIELD: begin
						if (top_hit) begin
							lvl_q  <= top_lvl;
							thr_q  <= tix(head_q[top_lvl]);
							next_q <= tix(head_q[top_lvl]);
						end else begin
							next_q <= idle_id_q;
						end
					end
					default: begin
					end
				endcase
			end
			S_WALK: begin
				if (head_q[lvl_q] != node_q && cnt_q == TW'(MAX_THREADS - 1)) begin
					status_q <= mprq_pkg::ST_NOT_FOUND;
				end
			end
			S_WCHK: begin
				if (p_id == node_q) begin
					status_q <= mprq_pkg::ST_NOT_FOUND;
				end else begin
					node_q <= p_id;
					cnt_q  <= cnt_q + TW'(1);
				end
			end
			S_UNWR: begin
				priority if (is_head && is_tail) begin
				end else if (is_head) begin
					head_q[lvl_q] <= n_id;
				end else if (is_tail) begin
					tail_q[lvl_q] <= p_id;
				end
			end
			S_YREQ: begin
				if (next_q != req_q.current_id) begin
					switched_q <= 1'b1;
					thr_q      <= req_q.current_id;
					lvl_q      <= lvl_c;
				end
			end
			S_PUSH: begin
				if (!nonempty_q[lvl_q]) begin
					head_q[lvl_q] <= thr_q;
					tail_q[lvl_q] <= thr_q;
				end
			end
			S_PUSH2: tail_q[lvl_q] <= thr_q;
			S_DONE: begin
				if (rsp_load) begin
					rsp_q <= '{next_thread_id: next_q, switched: switched_q,
						switch_pending: pending_q, status: status_q};
				end
			end
			default: begin
			end
		endcase
	end

	// checks
	`MPRQ_ASSERT(a_accept_exec, accept |=> state_q == S_EXEC, "accept did not start request")
	`MPRQ_ASSERT(a_walk_order, state_q == S_WCHK |-> $past(state_q) == S_WALK, "walk out of order")
	`MPRQ_ASSERT_ALWAYS(a_empty_levels, queued_q == '0 |-> nonempty_q == '0, "level without thread")

endmodule

// ===== rtl/core/mprq_link_ram.sv =====
// Next and previous link memories, one write port each, shared read address.
module mprq_link_ram #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  mprq_pkg::link_wr_t nx_wr,
	input  mprq_pkg::link_wr_t pv_wr,
	input  mprq_pkg::id_t      rd_addr,
	output mprq_pkg::id_t      nx_rdata,
	output mprq_pkg::id_t      pv_rdata
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	mprq_pkg::id_t nx_mem [DEPTH];
	mprq_pkg::id_t pv_mem [DEPTH];

	// next links
	always_ff @(posedge clk) begin
		if (nx_wr.we) begin
			nx_mem[AW'(nx_wr.addr)] <= nx_wr.data;
		end
		nx_rdata <= nx_mem[AW'(rd_addr)];
	end

	// previous links
	always_ff @(posedge clk) begin
		if (pv_wr.we) begin
			pv_mem[AW'(pv_wr.addr)] <= pv_wr.data;
		end
		pv_rdata <= pv_mem[AW'(rd_addr)];
	end

endmodule
